>>> hdl/ponu_pkg.sv
// Package for the octave noise accumulator: widths, constants, sequencer states.
// No dependencies.
`default_nettype none
package ponu_pkg;
	localparam int OctavesPerGroupDef = 9;
	localparam int FracBitsDef = 24;
	localparam int PermSize = 256;
	localparam int WorkBits = 28;
	localparam logic [31:0] WeightQ32 = 32'd2151686160;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOOKUP, ST_GRAD, ST_FADE, ST_LERP, ST_WEIGHT, ST_SCALE, ST_EMIT
	} state_t;

	function automatic logic [1:0] amp_of(input logic [4:0] j);
		case (j)
			5'd2, 5'd3, 5'd4: amp_of = 2'd2;
			default: amp_of = 2'd1;
		endcase
	endfunction

	// Gradient dot product for one hash nibble; operands are signed Q.28 in 32 bits.
	function automatic logic signed [33:0] grad_dot(input logic [3:0] h,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		logic signed [33:0] a;
		logic signed [33:0] b;
		a = (h < 4'd8) ? 34'(x) : 34'(y);
		b = (h < 4'd4) ? 34'(y) : ((h == 4'd12 || h == 4'd14) ? 34'(x) : 34'(z));
		if (h[0]) a = -a;
		if (h[1]) b = -b;
		grad_dot = a + b;
	endfunction
endpackage
`default_nettype wire

>>> hdl/ponu_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ponu_ram #(
	parameter int Width = 8,
	parameter int Depth = 4608
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> hdl/perlin_octave_noise_accumulator_unit.sv
// Octave noise accumulator: one permutation RAM, one shared multiplier, small sequencer.
// Loads are written at their accepting edge, so loads go one per cycle while the unit is idle;
// a sample holds the unit for 14 serial RAM lookups (each an issue and a capture phase), a
// gradient step, 12 fade and 7 lerp multiplies, a weighting and an accumulate step; the last
// octave adds an emit step, after which noise_value is valid; stall is high meanwhile.
// Reset: arst_n clears the sequencer, accumulator and output valid; RAM is not cleared.
`default_nettype none
module perlin_octave_noise_accumulator_unit #(
	parameter int OctavesPerGroup = ponu_pkg::OctavesPerGroupDef,
	parameter int FracBits = ponu_pkg::FracBitsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                func,
	input  wire logic [4:0]          octave,
	input  wire logic [7:0]          perm_index,
	input  wire logic [7:0]          perm_value,
	input  wire logic [7:0]          cell_x,
	input  wire logic [7:0]          cell_y,
	input  wire logic [7:0]          cell_z,
	input  wire logic [FracBits-1:0] frac_x,
	input  wire logic [FracBits-1:0] frac_y,
	input  wire logic [FracBits-1:0] frac_z,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       noise_value
);
	import ponu_pkg::*;

	localparam int NumOct = 2 * OctavesPerGroup;
	localparam int Depth = NumOct * PermSize;
	localparam int AW = $clog2(Depth);
	localparam logic signed [39:0] SumMax = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] SumMin = -40'sh80_0000_0000;
	localparam logic signed [63:0] One = 64'sd1 <<< WorkBits;

	state_t state_q, state_d;

	logic [4:0]  oct_q;
	logic [7:0]  sx_q, sy_q, sz_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic [3:0]  step_q;    // lookup / lerp index
	logic        phase_q;   // RAM read issue vs capture
	logic [7:0]  a_q [2];
	logic [7:0]  b_q [4];
	logic [3:0]  h_q [8];
	logic signed [63:0] g_q [8];
	logic signed [63:0] f_q [3];
	logic [1:0]  fi_q;      // which fade
	logic [1:0]  fs_q;      // fade step
	logic signed [63:0] p_q;
	logic signed [39:0] sum_q;
	logic signed [63:0] contrib_s1;
	logic        out_valid_q;
	logic signed [31:0] out_q;

	// Frac to Q.28
	function automatic logic signed [31:0] to_work(input logic [FracBits-1:0] f);
		logic [63:0] w;
		w = 64'(f);
		if (FracBits >= WorkBits) w = w >> (FracBits - WorkBits);
		else w = w << (WorkBits - FracBits);
		to_work = 32'(w);
	endfunction

	// shared multiplier: 34x34 signed product then floor shift
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [67:0] mul_p;
	assign mul_p = mul_a * mul_b;

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_rd;
	logic [7:0]    look_v;
	logic [1:0]    sb;      // y-level slot: bit0 x corner, bit1 y corner
	ponu_ram #(.Width(8), .Depth(Depth)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(perm_value), .rdata(ram_rd)
	);

	wire accept = in_valid && !in_stall;
	wire oct_ok = 32'(octave) < NumOct;

	// lookup key: steps 0-1 x, 2-5 y (b00, b10, b01, b11), 6-13 z
	always_comb begin
		sb = 2'(step_q - 4'd2);
		look_v = 8'd0;
		if (step_q < 4'd2) look_v = sx_q + 8'(step_q[0]);
		else if (step_q < 4'd6) look_v = a_q[sb[0]] + sy_q + 8'(sb[1]);
		else if (step_q < 4'd10) look_v = b_q[2'(step_q - 4'd6)] + sz_q;
		else look_v = b_q[2'(step_q - 4'd10)] + sz_q + 8'd1;
	end

	always_comb begin
		ram_we = accept && !func && oct_ok;
		if (accept) ram_addr = AW'(32'(octave) * PermSize + 32'(perm_index));
		else ram_addr = AW'(32'(oct_q) * PermSize + 32'(look_v));
	end

	// multiplier operand select
	logic signed [63:0] fade_t;
	logic [3:0] ls;
	logic signed [63:0] lo, hi, lf;
	always_comb begin
		fade_t = (fi_q == 2'd0) ? 64'(x_q) : (fi_q == 2'd1) ? 64'(y_q) : 64'(z_q);
		ls = step_q;
		// lerp schedule: 0-3 x level (into g 0,2,4,6), 4-5 y (into g0,g4), 6 z
		if (ls < 4'd4) begin
			lo = g_q[3'(2*ls)]; hi = g_q[3'(2*ls+1)]; lf = f_q[0];
		end else if (ls < 4'd6) begin
			lo = g_q[3'(4*(ls-4))]; hi = g_q[3'(4*(ls-4)+2)]; lf = f_q[1];
		end else begin
			lo = g_q[0]; hi = g_q[4]; lf = f_q[2];
		end
		mul_a = 34'sd0; mul_b = 34'sd0;
		unique case (state_q)
			ST_FADE: begin
				mul_a = (fs_q == 2'd0) ? 34'(6 * fade_t - 15 * One) : 34'(p_q);
				mul_b = 34'(fade_t);
			end
			ST_LERP: begin
				mul_a = 34'(hi - lo);
				mul_b = 34'(lf);
			end
			ST_WEIGHT: begin
				mul_a = 34'(g_q[0]);
				mul_b = $signed({1'b0, WeightQ32, 1'b0}) >>> 1;
			end
			default: ;
		endcase
	end
	wire signed [63:0] mul_sh = 64'(mul_p >>> WorkBits);

	logic [4:0] j;
	always_comb j = (32'(oct_q) >= OctavesPerGroup) ? 5'(32'(oct_q) - OctavesPerGroup)
		: oct_q;

	// saturating accumulate and output scaling
	logic signed [41:0] sum3;
	logic signed [41:0] v;
	logic signed [39:0] sum_n;
	logic signed [63:0] sum_w;
	always_comb begin
		sum_w = 64'(sum_q) + contrib_s1;
		if (sum_w > 64'(SumMax)) sum_n = SumMax;
		else if (sum_w < 64'(SumMin)) sum_n = SumMin;
		else sum_n = 40'(sum_w);
		sum3 = 42'(sum_q) * 42'sd3;
		v = sum3 >>> 9;
	end

	// the emit step waits only while an earlier result is still stalled at the output
	wire out_free = !out_valid_q || !out_stall;
	wire emit_go = (state_q == ST_EMIT) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (accept && func && oct_ok) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: if (phase_q && step_q == 4'd13) state_d = ST_GRAD;
			ST_GRAD: state_d = ST_FADE;
			ST_FADE: if (fi_q == 2'd2 && fs_q == 2'd3) state_d = ST_LERP;
			ST_LERP: if (step_q == 4'd6) state_d = ST_WEIGHT;
			ST_WEIGHT: state_d = ST_SCALE;
			ST_SCALE: state_d = (32'(oct_q) == NumOct - 1) ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			out_valid_q <= 1'b0;
			step_q <= '0;
			phase_q <= 1'b0;
			fi_q <= '0;
			fs_q <= '0;
		end else begin
			if (emit_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0; phase_q <= 1'b0; fi_q <= '0; fs_q <= '0;
				end
				ST_LOOKUP: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						step_q <= (step_q == 4'd13) ? 4'd0 : step_q + 4'd1;
					end
				end
				ST_FADE: begin
					fs_q <= fs_q + 2'd1;
					if (fs_q == 2'd3) fi_q <= fi_q + 2'd1;
				end
				ST_LERP: step_q <= step_q + 4'd1;
				ST_SCALE: sum_q <= sum_n;
				ST_EMIT: if (out_free) sum_q <= '0;
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			oct_q <= octave;
			sx_q <= cell_x; sy_q <= cell_y; sz_q <= cell_z;
			x_q <= to_work(frac_x); y_q <= to_work(frac_y); z_q <= to_work(frac_z);
		end
		unique case (state_q)
			ST_LOOKUP: if (phase_q) begin
				if (step_q < 4'd2) a_q[step_q[0]] <= ram_rd;
				else if (step_q < 4'd6) b_q[sb] <= ram_rd;
				else h_q[3'(step_q - 4'd6)] <= ram_rd[3:0];
			end
			ST_GRAD: begin
				for (int k = 0; k < 8; k++) begin
					g_q[k] <= 64'(grad_dot(h_q[k],
						k[0] ? x_q - 32'(One) : x_q,
						k[1] ? y_q - 32'(One) : y_q,
						k[2] ? z_q - 32'(One) : z_q));
				end
			end
			ST_FADE: begin
				if (fs_q == 2'd0) p_q <= mul_sh + 10 * One;
				else p_q <= mul_sh;
				if (fs_q == 2'd3) f_q[fi_q] <= mul_sh;
			end
			ST_LERP: begin
				if (ls < 4'd4) g_q[3'(2*ls)] <= lo + mul_sh;
				else if (ls < 4'd6) g_q[3'(4*(ls-4))] <= lo + mul_sh;
				else g_q[0] <= lo + mul_sh;
			end
			// amp is 1 or 2, so the amplitude is a shift
			ST_WEIGHT: contrib_s1 <= 64'(((amp_of(j) == 2'd2) ? (mul_p <<< 1) : mul_p)
				>>> (WorkBits + 32'(j)));
			ST_EMIT: if (out_free) begin
				if (v > 42'sd2147483647) out_q <= 32'sh7FFF_FFFF;
				else if (v < -42'sd2147483648) out_q <= 32'sh8000_0000;
				else out_q <= 32'(v);
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign noise_value = out_q;

`ifndef ASSERT_OFF
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("accepted while busy");
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> sum_q == 40'sd0) else $error("sum not cleared");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(noise_value)) else $error("output moved");
`endif
endmodule
`default_nettype wire
